// ----- hdl/lrs_pkg.sv -----
// shared types and constants for the life row stencil
// used by lrs_oq and life_row_stencil; depends on nothing
package lrs_pkg;

  // fixed field widths
  localparam int ROW_W         = 64;
  localparam int GW_W          = 7;
  localparam int MAX_WIDTH_DEF = 64;
  localparam logic [GW_W-1:0] GRID_WIDTH_RST = 7'd64;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // result queue depth, a power of two of at least four
  localparam int OQ_DEPTH = 4;

  // register index, taken from the word address
  typedef enum logic [0:0] {
    REG_GRID_WIDTH = 1'b0
  } reg_idx_e;

  // one result in the output queue
  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             is_final;
  } res_t;

  // queue write enables; en1 is only set together with en0
  typedef struct packed {
    logic en0;
    logic en1;
  } push_t;

endpackage

// ----- hdl/lrs_lane.sv -----
// one cell of the stencil: neighbour count and the birth/survival rule
// depends on nothing
module lrs_lane (
  input  logic [7:0] nbr_i,
  input  logic       alive_i,
  output logic       next_o
);

  logic [3:0] count;

  // population count of the eight neighbours
  always_comb begin
    count = 4'd0;
    for (int k = 0; k < 8; k++) begin
      count = count + {3'd0, nbr_i[k]};
    end
  end

  // born on three, survives on two or three
  assign next_o = (count == 4'd3) || (alive_i && (count == 4'd2));

endmodule

// ----- hdl/lrs_gen.sv -----
// one row of stencil lanes plus the merging stage that masks the result
// depends on lrs_lane
module lrs_gen #(
  parameter int W = 64
) (
  input  logic [W-1:0] up_i,
  input  logic [W-1:0] mid_i,
  input  logic [W-1:0] down_i,
  input  logic [W-1:0] mask_i,
  output logic [W-1:0] next_o
);

  // rows padded with a dead column on each side
  logic [W+1:0] up_p;
  logic [W+1:0] mid_p;
  logic [W+1:0] down_p;
  logic [W-1:0] lane_out;

  assign up_p   = {1'b0, up_i, 1'b0};
  assign mid_p  = {1'b0, mid_i, 1'b0};
  assign down_p = {1'b0, down_i, 1'b0};

  // one lane per column
  for (genvar c = 0; c < W; c++) begin : g_lane
    lrs_lane u_lane (
      .nbr_i   ({up_p[c+2:c], mid_p[c+2], mid_p[c], down_p[c+2:c]}),
      .alive_i (mid_p[c+1]),
      .next_o  (lane_out[c])
    );
  end

  // merge lanes, dropping columns beyond the width
  assign next_o = lane_out & mask_i;

endmodule

// ----- hdl/lrs_oq.sv -----
// small result queue taking up to two results a cycle and giving one while not stalled
// depends on lrs_pkg
module lrs_oq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrs_pkg::push_t    push_i,
  input  lrs_pkg::res_t     d0_i,
  input  lrs_pkg::res_t     d1_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output lrs_pkg::res_t     head_o
);

  localparam int DEPTH = lrs_pkg::OQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrs_pkg::res_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  assign pop     = valid_o && !stall_i;
  assign n_push  = CNT_W'(push_i.en0) + CNT_W'(push_i.en1);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  // room for two more requests is needed to take an item
  assign full_o  = (count_q > CNT_W'(DEPTH - 2));

  // pointer and fill arithmetic
  always_comb begin
    wr_d    = wr_q + PTR_W'(n_push);
    rd_d    = rd_q + PTR_W'(pop);
    count_d = count_q + n_push - CNT_W'(pop);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // storage, two write slots
  always_ff @(posedge clk_i) begin
    if (push_i.en0) begin
      mem_q[wr_q] <= d0_i;
    end
    if (push_i.en1) begin
      mem_q[wr_q + PTR_W'(1)] <= d1_i;
    end
  end

endmodule

// ----- hdl/life_row_stencil.sv -----
// life row stencil: one b3/s23 generation over a streamed grid, one row per request
// a result enters the result queue as the row that causes it is taken
// throughput: one row per cycle; a last row can add a second result, held in a
// four-deep result queue, and input stalls once three results are queued
// reset: grid_width returns to 64, held rows and the result queue are emptied
// depends on lrs_pkg, lrs_gen, lrs_lane and lrs_oq
module life_row_stencil #(
  parameter int MAX_WIDTH = lrs_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [lrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [lrs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // row input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lrs_pkg::ROW_W-1:0]    row_cells_i,
  input  logic                         first_row_i,
  input  logic                         last_row_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lrs_pkg::ROW_W-1:0]    next_cells_o,
  output logic                         final_row_o
);

  localparam int W    = MAX_WIDTH;
  localparam int GW_W = lrs_pkg::GW_W;

  logic [GW_W-1:0] grid_width_q;
  logic [GW_W-1:0] width_sat;
  logic [W-1:0]    mask;
  logic [W-1:0]    above_q, mid_q;
  logic            held_q;
  logic [W-1:0]    cur;
  logic [W-1:0]    mid_eff;
  logic [W-1:0]    res_a, res_b;
  logic            in_fire, fresh, emit0, emit1, cfg_wr;
  lrs_pkg::reg_idx_e reg_idx;
  lrs_pkg::push_t  push;
  lrs_pkg::res_t   d0, d1, head;

  // register port decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = lrs_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      lrs_pkg::REG_GRID_WIDTH: prdata = lrs_pkg::PDATA_W'(grid_width_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= lrs_pkg::GRID_WIDTH_RST;
    end else if (cfg_wr && (reg_idx == lrs_pkg::REG_GRID_WIDTH)) begin
      grid_width_q <= pwdata[GW_W-1:0];
    end
  end

  // column mask from the saturated width
  assign width_sat = (grid_width_q > GW_W'(W)) ? GW_W'(W) : grid_width_q;

  for (genvar c = 0; c < W; c++) begin : g_mask
    assign mask[c] = (GW_W'(c) < width_sat);
  end

  // request handling
  assign in_fire = in_valid_i && !in_stall_o;
  assign cur     = row_cells_i[W-1:0] & mask;
  assign fresh   = first_row_i || !held_q;
  assign mid_eff = fresh ? '0 : mid_q;
  assign emit0   = in_fire && !fresh;
  assign emit1   = in_fire && last_row_i;

  // middle row's next generation, with the new row below
  lrs_gen #(.W(W)) u_gen_mid (
    .up_i   (above_q),
    .mid_i  (mid_q),
    .down_i (cur),
    .mask_i (mask),
    .next_o (res_a)
  );

  // new row's next generation, dead row below, for a last row
  lrs_gen #(.W(W)) u_gen_last (
    .up_i   (mid_eff),
    .mid_i  (cur),
    .down_i ('0),
    .mask_i (mask),
    .next_o (res_b)
  );

  // pack results in order into the queue
  always_comb begin
    push.en0    = emit0 || emit1;
    push.en1    = emit0 && emit1;
    d1.cells    = lrs_pkg::ROW_W'(res_b);
    d1.is_final = 1'b1;
    if (emit0) begin
      d0.cells    = lrs_pkg::ROW_W'(res_a);
      d0.is_final = 1'b0;
    end else begin
      d0 = d1;
    end
  end

  // row window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= '0;
      mid_q   <= '0;
      held_q  <= 1'b0;
    end else if (in_fire) begin
      if (last_row_i) begin
        above_q <= '0;
        mid_q   <= '0;
        held_q  <= 1'b0;
      end else begin
        above_q <= mid_eff;
        mid_q   <= cur;
        held_q  <= 1'b1;
      end
    end
  end

  lrs_oq u_oq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .d0_i    (d0),
    .d1_i    (d1),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign next_cells_o = head.cells;
  assign final_row_o  = head.is_final;

  // checks
  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_row_i |=> out_valid_o)
    else $error("last row left no result");

  a_stall_needs_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty queue");

  a_last_clears_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_row_i |=> !held_q)
    else $error("rows still held after last row");

  a_held_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && held_q && !first_row_i |=> out_valid_o)
    else $error("held middle row gave no result");

endmodule
